// File: hw/rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;
    localparam int POOL_SIZE_DEF = 4096;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int REQ_W = 13;
    localparam int OFF_W = 12;
    localparam int ST_W = 2;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_DONE = 4'b1000
    } t_state;
endpackage

// File: hw/rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: free and used tables as rows of cells.
//  channel   dir  handshake            payload
//  s_axis    in   s_axis_tvalid/tready tdata: req_size[12:0], block_offset[24:13]; tuser: cmd
//  m_axis    out  m_axis_tvalid/tready tdata: grant_offset[11:0], status[13:12]
//  cfg       in   i_cfg_we             i_cfg_wdata: split_slack
// An item is processed as one scan step per table entry, then an update step in
// which both cell rows shift or load in place, then delivery.
// Reset restores both tables. The result waits in the output register until taken;
// the next item is accepted once it has been taken.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_size, block_offset
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // grant_offset, status
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata     // split_slack
);
    localparam int AW = $clog2(POOL_SIZE + 1) > REQ_W ? $clog2(POOL_SIZE + 1) : REQ_W;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state;
    logic [REQ_W-1:0] r_slack, r_req;
    logic [OFF_W-1:0] r_boff;
    logic r_cmd;
    logic [CW-1:0] r_free_cnt, r_used_cnt, r_scan;
    logic [IW-1:0] r_hit;
    logic r_found;
    logic [OFF_W-1:0] r_grant;
    logic [ST_W-1:0] r_status;

    logic [AW-1:0] f_off [TABLE_DEPTH];
    logic [AW-1:0] f_size[TABLE_DEPTH];
    logic          f_val [TABLE_DEPTH];
    logic [AW-1:0] u_off [TABLE_DEPTH];
    logic [AW-1:0] u_size[TABLE_DEPTH];
    logic          u_val [TABLE_DEPTH];

    logic [AW-1:0] fl_off [TABLE_DEPTH];
    logic [AW-1:0] fl_size[TABLE_DEPTH];
    logic          fl_val [TABLE_DEPTH];
    logic          fl_ld  [TABLE_DEPTH];
    logic [AW-1:0] ul_off [TABLE_DEPTH];
    logic [AW-1:0] ul_size[TABLE_DEPTH];
    logic          ul_val [TABLE_DEPTH];
    logic          ul_ld  [TABLE_DEPTH];

    logic [IW-1:0] scan_ix;
    logic [AW-1:0] req_w, hit_off, hit_size, grant_sz, left_sz, at_w, blk_off, blk_size;
    logic [AW:0]   sum_w;
    logic          scan_hit, do_update;

    assign scan_ix = r_scan[IW-1:0];
    assign req_w = AW'(r_req);
    assign hit_off = f_off[r_hit];
    assign hit_size = f_size[r_hit];
    assign sum_w = (AW+1)'(r_req) + (AW+1)'(r_slack);
    assign grant_sz = (sum_w >= (AW+1)'(hit_size)) ? hit_size : req_w;
    assign left_sz = hit_size - grant_sz;
    assign at_w = hit_off + left_sz;
    assign blk_off = u_off[r_hit];
    assign blk_size = u_size[r_hit];

    always_comb begin
        scan_hit = 1'b0;
        if (r_cmd == 1'b0) begin
            scan_hit = (r_scan < r_free_cnt) && (f_size[scan_ix] > req_w);
        end else begin
            scan_hit = (r_scan < r_used_cnt) &&
                       (u_off[IW'(r_used_cnt - CW'(1) - r_scan)] == AW'(r_boff));
        end
    end

    assign do_update = (r_state == S_EXEC) && r_found &&
        ((r_cmd == 1'b0) ? (r_req != '0 && r_used_cnt < CW'(TABLE_DEPTH))
                         : (r_free_cnt < CW'(TABLE_DEPTH)));

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cells
            always_comb begin
                fl_ld[g] = 1'b0;
                fl_off[g] = f_off[g];
                fl_size[g] = f_size[g];
                fl_val[g] = f_val[g];
                ul_ld[g] = 1'b0;
                ul_off[g] = u_off[g];
                ul_size[g] = u_size[g];
                ul_val[g] = u_val[g];
                if (do_update && r_cmd == 1'b0) begin
                    if (IW'(g) == r_used_cnt[IW-1:0]) begin
                        ul_ld[g] = 1'b1;
                        ul_off[g] = at_w;
                        ul_size[g] = grant_sz;
                        ul_val[g] = 1'b1;
                    end
                    if (IW'(g) == r_hit) begin
                        fl_ld[g] = 1'b1;
                        fl_size[g] = left_sz;
                    end
                    if (left_sz == '0 && IW'(g) >= r_hit) begin
                        fl_ld[g] = 1'b1;
                        if (g + 1 < TABLE_DEPTH) begin
                            fl_off[g] = f_off[(g + 1) % TABLE_DEPTH];
                            fl_size[g] = f_size[(g + 1) % TABLE_DEPTH];
                            fl_val[g] = f_val[(g + 1) % TABLE_DEPTH];
                        end else begin
                            fl_val[g] = 1'b0;
                        end
                    end
                end else if (do_update) begin
                    if (IW'(g) >= r_hit) begin
                        ul_ld[g] = 1'b1;
                        if (g + 1 < TABLE_DEPTH) begin
                            ul_off[g] = u_off[(g + 1) % TABLE_DEPTH];
                            ul_size[g] = u_size[(g + 1) % TABLE_DEPTH];
                            ul_val[g] = u_val[(g + 1) % TABLE_DEPTH];
                        end
                    end
                    if (!f_val[g] || f_off[g] <= blk_off) begin
                        fl_ld[g] = 1'b1;
                        if (g == 0 || !(f_val[(g + TABLE_DEPTH - 1) % TABLE_DEPTH] &&
                                f_off[(g + TABLE_DEPTH - 1) % TABLE_DEPTH] > blk_off)) begin
                            if (g > 0) begin
                                fl_off[g] = f_off[(g + TABLE_DEPTH - 1) % TABLE_DEPTH];
                                fl_size[g] = f_size[(g + TABLE_DEPTH - 1) % TABLE_DEPTH];
                                fl_val[g] = f_val[(g + TABLE_DEPTH - 1) % TABLE_DEPTH];
                            end
                        end
                        if (g == 0 || (f_val[(g + TABLE_DEPTH - 1) % TABLE_DEPTH] &&
                                f_off[(g + TABLE_DEPTH - 1) % TABLE_DEPTH] > blk_off)) begin
                            fl_off[g] = blk_off;
                            fl_size[g] = blk_size;
                            fl_val[g] = 1'b1;
                        end
                    end
                end
            end

            ffba_cell #(.AW(AW)) u_free (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_rst_valid(g == 0), .i_rst_off('0),
                .i_rst_size(g == 0 ? AW'(POOL_SIZE) : '0),
                .i_load(fl_ld[g]), .i_load_off(fl_off[g]), .i_load_size(fl_size[g]),
                .i_load_valid(fl_val[g]),
                .o_off(f_off[g]), .o_size(f_size[g]), .o_valid(f_val[g])
            );
            ffba_cell #(.AW(AW)) u_used (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_rst_valid(1'b0), .i_rst_off('0), .i_rst_size('0),
                .i_load(ul_ld[g]), .i_load_off(ul_off[g]), .i_load_size(ul_size[g]),
                .i_load_valid(ul_val[g]),
                .o_off(u_off[g]), .o_size(u_size[g]), .o_valid(u_val[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slack <= REQ_W'(4);
            r_free_cnt <= CW'(1);
            r_used_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_slack <= i_cfg_wdata[REQ_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd <= s_axis_tuser;
                        r_req <= s_axis_tdata[REQ_W-1:0];
                        r_boff <= s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
                        r_scan <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_hit && !r_found) begin
                        r_found <= 1'b1;
                        r_hit <= (r_cmd == 1'b0) ? scan_ix
                                                 : IW'(r_used_cnt - CW'(1) - r_scan);
                    end
                    if (r_scan == CW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_EXEC;
                    end
                    r_scan <= r_scan + CW'(1);
                end
                S_EXEC: begin
                    r_grant <= '0;
                    if (r_cmd == 1'b0) begin
                        if (r_req == '0 || !r_found) begin
                            r_status <= ST_NOFIT;
                        end else if (!do_update) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                            r_grant <= at_w[OFF_W-1:0];
                            r_used_cnt <= r_used_cnt + CW'(1);
                            if (left_sz == '0) begin
                                r_free_cnt <= r_free_cnt - CW'(1);
                            end
                        end
                    end else begin
                        if (!r_found) begin
                            r_status <= ST_UNKNOWN;
                        end else if (!do_update) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                            r_free_cnt <= r_free_cnt + CW'(1);
                            r_used_cnt <= r_used_cnt - CW'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tdata = {2'b00, r_status, r_grant};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CW'(TABLE_DEPTH) && r_used_cnt <= CW'(TABLE_DEPTH))
        else $error("table count overflow");
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> ((CW+1)'(r_free_cnt) + (CW+1)'(r_used_cnt)) >=
            (CW+1)'($past(r_free_cnt)) || $past(r_cmd))
        else $error("allocation lost a free block count");
    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_status != ST_OK |-> r_grant == '0)
        else $error("failed item reports nonzero offset");
endmodule

// File: hw/rtl/ffba_cell.sv
// One table entry cell: holds offset, size and valid bit; supports reset and load (shifts are loads of a neighbour).
module ffba_cell
    import ffba_pkg::*;
#(
    parameter int AW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rst_valid,
    input  logic [AW-1:0] i_rst_off,
    input  logic [AW-1:0] i_rst_size,
    input  logic          i_load,
    input  logic [AW-1:0] i_load_off,
    input  logic [AW-1:0] i_load_size,
    input  logic          i_load_valid,
    output logic [AW-1:0] o_off,
    output logic [AW-1:0] o_size,
    output logic          o_valid
);
    logic [AW-1:0] r_off, r_size;
    logic          r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= i_rst_valid;
            r_off   <= i_rst_off;
            r_size  <= i_rst_size;
        end else if (i_load) begin
            r_valid <= i_load_valid;
            r_off   <= i_load_off;
            r_size  <= i_load_size;
        end
    end

    assign o_off = r_off;
    assign o_size = r_size;
    assign o_valid = r_valid;
endmodule
